FILE: design/pdrc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdrc_pkg
// Types, widths and fixed-point constants of the pump duty ramp controller.
// ----------------------------------------------------------------------------
package pdrc_pkg;

    // timing constants in ms
    localparam int TICK_MS          = 10;
    localparam int UPDATE_PERIOD_MS = 100;
    localparam int TO_PREFUSION_MS  = 1000;
    localparam int TO_BREW_MS       = 1000;

    // field and state widths
    localparam int DUTY_W    = 10;
    localparam int FRAC_BITS = 8;
    localparam int VAL_W     = DUTY_W + FRAC_BITS;  // Q10.8 duty
    localparam int CNT_W     = 16;
    localparam int RATE_W    = 16;                  // signed Q.12 counts per ms
    localparam int RATE_FRAC = 12;
    localparam int PCT_W     = 7;
    localparam int MODE_W    = 2;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam int PCT_MAX   = 100;
    localparam int RATE_MIN  = 164;    // 0.04 in Q.12
    localparam int RATE_MAX  = 1229;   // 0.3 in Q.12
    localparam int RATE_POS_SAT = 32767;
    localparam int RATE_NEG_SAT = 32768;

    localparam logic [DUTY_W-1:0] MAX_DUTY_RST  = 10'd1023;
    localparam logic [DUTY_W-1:0] PREF_DUTY_RST = 10'd512;
    localparam logic [DUTY_W-1:0] OFF_DUTY_RST  = 10'd0;
    localparam logic [CNT_W-1:0]  INIT_TICKS_RST = 16'd300;

    // shared multiplier
    localparam int MUL_W  = 27;
    localparam int PROD_W = 2 * MUL_W;
    localparam int PM_W   = 17;                     // percent * max_duty
    localparam int Q_SHIFT = RATE_FRAC - FRAC_BITS; // Q.12 to Q.8
    localparam int STEP_W = 23;
    localparam int V_W    = STEP_W + 1;

    // target = (pct * max * 256 + 50) / 100 by reciprocal
    localparam int TGT_DIV   = 100;
    localparam int TGT_ROUND = 50;
    localparam int TGT_XB    = PM_W + FRAC_BITS;
    localparam int TGT_S     = TGT_XB + $clog2(TGT_DIV);
    localparam longint TGT_M =
        ((longint'(1) << TGT_S) + longint'(TGT_DIV) - 1) / longint'(TGT_DIV);

    // rate = (|diff| * 16) / ms by reciprocal, |diff| * 16 below 2^DIFF_XB
    localparam int DIFF_XB = VAL_W + 4;
    localparam int Q_W     = DIFF_XB + 1;
    localparam int S_UPD   = DIFF_XB + $clog2(UPDATE_PERIOD_MS);
    localparam int S_PREF  = DIFF_XB + $clog2(TO_PREFUSION_MS);
    localparam int S_BREW  = DIFF_XB + $clog2(TO_BREW_MS);
    localparam longint M_UPD = ((longint'(1) << S_UPD) + longint'(UPDATE_PERIOD_MS) - 1)
                               / longint'(UPDATE_PERIOD_MS);
    localparam longint M_PREF = ((longint'(1) << S_PREF) + longint'(TO_PREFUSION_MS) - 1)
                                / longint'(TO_PREFUSION_MS);
    localparam longint M_BREW = ((longint'(1) << S_BREW) + longint'(TO_BREW_MS) - 1)
                                / longint'(TO_BREW_MS);

    typedef enum logic [MODE_W-1:0] {
        MODE_INIT      = 2'd0,
        MODE_PREFUSION = 2'd1,
        MODE_BREW      = 2'd2
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_DUTY   = 2'd0,
        CFG_PREF_DUTY  = 2'd1,
        CFG_OFF_DUTY   = 2'd2,
        CFG_INIT_TICKS = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MUL_PCT  = 2'd0,
        MUL_TGT  = 2'd1,
        MUL_DIFF = 2'd2,
        MUL_STEP = 2'd3
    } t_mul_sel;

    typedef enum logic [1:0] {
        DIV_UPD  = 2'd0,
        DIV_PREF = 2'd1,
        DIV_BREW = 2'd2
    } t_div_sel;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'd0,
        ST_PCT   = 4'd1,
        ST_TGT   = 4'd2,
        ST_WTGT  = 4'd3,
        ST_MAG   = 4'd4,
        ST_URATE = 4'd5,
        ST_MODE  = 4'd6,
        ST_STEP  = 4'd7,
        ST_XMUL  = 4'd8,
        ST_XRATE = 4'd9,
        ST_DONE  = 4'd10
    } t_state;

    typedef struct packed {
        logic     load_in;
        logic     mul_en;
        t_mul_sel mul_sel;
        t_div_sel div_sel;
        logic     tgt_prod;
        logic     tgt_pref;
        logic     tgt_full;
        logic     rate_upd;
        logic     rate_x;
        logic     rate_zero;
        logic     val_full;
        logic     val_step;
        logic     cnt_step;
        logic     cnt_clr;
        logic     last_load;
        logic     out_load;
        t_mode    mode;
    } t_dp_cmd;

    typedef struct packed {
        logic du_in;
        logic pe;
        logic last_pe;
        logic init_done;
        logic out_free;
    } t_dp_sts;

endpackage
`default_nettype wire

FILE: design/pdrc_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdrc_in_if
// Tick channel: valid/ready with the prefusion enable and duty command.
// ----------------------------------------------------------------------------
interface pdrc_in_if
    import pdrc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             prefusion_enable;
    logic             duty_update;
    logic [PCT_W-1:0] duty_percent;

    modport source (
        output valid, prefusion_enable, duty_update, duty_percent,
        input  ready
    );
    modport sink (
        input  valid, prefusion_enable, duty_update, duty_percent,
        output ready
    );
endinterface
`default_nettype wire

FILE: design/pdrc_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdrc_out_if
// Result channel: valid/ready with the pwm duty and the current mode.
// ----------------------------------------------------------------------------
interface pdrc_out_if
    import pdrc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] pwm_duty;
    logic [MODE_W-1:0] mode_now;

    modport source (
        output valid, pwm_duty, mode_now,
        input  ready
    );
    modport sink (
        input  valid, pwm_duty, mode_now,
        output ready
    );
endinterface
`default_nettype wire

FILE: design/pdrc_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdrc_dp
// Datapath: config registers, duty/target/rate state, one shared multiplier
// with reciprocal division, ramp step with clamps, and the output register.
// ----------------------------------------------------------------------------
module pdrc_dp
    import pdrc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_pe,
    input  wire logic                 i_du,
    input  wire logic [PCT_W-1:0]     i_pct,
    input  wire logic                 i_out_ready,
    input  wire t_dp_cmd              i_cmd,
    output t_dp_sts                   o_sts,
    output logic                      o_out_valid,
    output logic [DUTY_W-1:0]         o_pwm,
    output logic [MODE_W-1:0]         o_mode
);

    logic [DUTY_W-1:0]        r_max, r_pref, r_off;
    logic [CNT_W-1:0]         r_init_ticks;
    logic                     r_pe, r_last;
    logic [PCT_W-1:0]         r_pct;
    logic [CNT_W-1:0]         r_count;
    logic [VAL_W-1:0]         r_value, r_target;
    logic signed [RATE_W-1:0] r_rate;
    logic                     r_pos;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_out_valid;
    logic [DUTY_W-1:0]        r_pwm;
    t_mode                    r_mode_out;

    logic [PCT_W-1:0]         pct_sat;
    logic [PROD_W-1:0]        prod_u;
    logic [TGT_XB-1:0]        tgt_num;
    logic signed [VAL_W:0]    diff;
    logic [VAL_W-1:0]         diff_mag;
    logic signed [MUL_W-1:0]  mul_a, mul_b, div_m;
    logic signed [PROD_W-1:0] mul_p;
    logic [Q_W-1:0]           quo;
    logic [RATE_W-1:0]        upd_mag;
    logic signed [RATE_W-1:0] upd_rate, x_rate;
    logic signed [STEP_W-1:0] step;
    logic signed [V_W-1:0]    v_sum, v_clip, tgt_s, lo_s, hi_s;
    logic [VAL_W-1:0]         step_val, full_val, pref_val;
    logic [CNT_W-1:0]         cnt_inc;

    assign pct_sat  = (i_pct > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : i_pct;
    assign prod_u   = r_prod;
    assign tgt_num  = {prod_u[PM_W-1:0], FRAC_BITS'(0)} + TGT_XB'(TGT_ROUND);
    assign diff     = $signed({1'b0, r_target}) - $signed({1'b0, r_value});
    assign diff_mag = diff[VAL_W] ? VAL_W'(-diff) : diff[VAL_W-1:0];
    assign full_val = {r_max, FRAC_BITS'(0)};
    assign pref_val = {r_pref, FRAC_BITS'(0)};

    // reciprocal and its shift for each divisor
    always_comb begin
        case (i_cmd.div_sel)
            DIV_UPD: begin
                div_m = MUL_W'(M_UPD);
                quo   = Q_W'(prod_u >> S_UPD);
            end
            DIV_PREF: begin
                div_m = MUL_W'(M_PREF);
                quo   = Q_W'(prod_u >> S_PREF);
            end
            DIV_BREW: begin
                div_m = MUL_W'(M_BREW);
                quo   = Q_W'(prod_u >> S_BREW);
            end
            default: begin
                div_m = '0;
                quo   = '0;
            end
        endcase
    end

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_PCT: begin
                mul_a = MUL_W'(r_pct);
                mul_b = MUL_W'(r_max);
            end
            MUL_TGT: begin
                mul_a = MUL_W'(tgt_num);
                mul_b = MUL_W'(TGT_M);
            end
            MUL_DIFF: begin
                mul_a = MUL_W'({diff_mag, 4'b0000});
                mul_b = div_m;
            end
            MUL_STEP: begin
                mul_a = {{(MUL_W-RATE_W){r_rate[RATE_W-1]}}, r_rate};
                mul_b = MUL_W'(TICK_MS);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // rate after a duty update, magnitude clamped to 0.04..0.3
    assign upd_mag  = (quo < Q_W'(RATE_MIN)) ? RATE_W'(RATE_MIN) :
                      (quo > Q_W'(RATE_MAX)) ? RATE_W'(RATE_MAX) : RATE_W'(quo);
    assign upd_rate = r_pos ? $signed(upd_mag) : -$signed(upd_mag);

    // rate towards a new mode target, saturated to 16 bits signed
    assign x_rate = r_pos ?
        ((quo > Q_W'(RATE_POS_SAT)) ? $signed(RATE_W'(RATE_POS_SAT)) : $signed(RATE_W'(quo))) :
        ((quo > Q_W'(RATE_NEG_SAT)) ? $signed(RATE_W'(RATE_NEG_SAT)) :
                                      $signed(RATE_W'(Q_W'(0) - quo)));

    // step is rate * tick floored from Q.12 to Q.8
    assign step  = STEP_W'(r_prod >>> Q_SHIFT);
    assign v_sum = $signed({{(V_W-VAL_W){1'b0}}, r_value}) + {step[STEP_W-1], step};
    assign tgt_s = $signed({{(V_W-VAL_W){1'b0}}, r_target});
    assign lo_s  = $signed({{(V_W-VAL_W){1'b0}}, r_off, FRAC_BITS'(0)});
    assign hi_s  = $signed({{(V_W-VAL_W){1'b0}}, full_val});

    always_comb begin
        v_clip = v_sum;
        if (!r_rate[RATE_W-1]) begin
            if (v_clip > tgt_s) v_clip = tgt_s;
        end else begin
            if (v_clip < tgt_s) v_clip = tgt_s;
        end
        if (v_clip < lo_s) v_clip = lo_s;
        // upper clamp wins when off is above max
        if (v_clip > hi_s) v_clip = hi_s;
        step_val = v_clip[VAL_W-1:0];
    end

    assign cnt_inc = (r_count == '1) ? r_count : r_count + 1'b1;

    always_comb begin
        o_sts.du_in     = i_du;
        o_sts.pe        = r_pe;
        o_sts.last_pe   = r_last;
        o_sts.init_done = (cnt_inc >= r_init_ticks);
        o_sts.out_free  = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max        <= MAX_DUTY_RST;
            r_pref       <= PREF_DUTY_RST;
            r_off        <= OFF_DUTY_RST;
            r_init_ticks <= INIT_TICKS_RST;
            r_last       <= 1'b0;
            r_count      <= '0;
            r_value      <= '0;
            r_target     <= '0;
            r_rate       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_MAX_DUTY:   r_max        <= i_cfg_data[DUTY_W-1:0];
                    CFG_PREF_DUTY:  r_pref       <= i_cfg_data[DUTY_W-1:0];
                    CFG_OFF_DUTY:   r_off        <= i_cfg_data[DUTY_W-1:0];
                    CFG_INIT_TICKS: r_init_ticks <= i_cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.last_load) r_last <= r_pe;
            if (i_cmd.cnt_clr) begin
                r_count <= '0;
            end else if (i_cmd.cnt_step) begin
                r_count <= cnt_inc;
            end
            if (i_cmd.val_full) begin
                r_value <= full_val;
            end else if (i_cmd.val_step) begin
                r_value <= step_val;
            end
            if (i_cmd.tgt_prod) begin
                r_target <= prod_u[TGT_S +: VAL_W];
            end else if (i_cmd.tgt_pref) begin
                r_target <= pref_val;
            end else if (i_cmd.tgt_full) begin
                r_target <= full_val;
            end
            if (i_cmd.rate_upd) begin
                r_rate <= upd_rate;
            end else if (i_cmd.rate_x) begin
                r_rate <= x_rate;
            end else if (i_cmd.rate_zero) begin
                r_rate <= '0;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_pe  <= i_pe;
            r_pct <= pct_sat;
        end
        if (i_cmd.mul_en) r_prod <= mul_p;
        if (i_cmd.mul_en && i_cmd.mul_sel == MUL_DIFF) r_pos <= (diff > 0);
        if (i_cmd.out_load) begin
            r_pwm      <= r_value[VAL_W-1:FRAC_BITS];
            r_mode_out <= i_cmd.mode;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pwm       = r_pwm;
    assign o_mode      = r_mode_out;

endmodule
`default_nettype wire

FILE: design/pdrc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdrc_ctrl
// Controller: sequences one tick through the datapath and holds the mode.
// ----------------------------------------------------------------------------
module pdrc_ctrl
    import pdrc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    t_state r_state, n_state;
    t_mode  r_mode, n_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_mode  <= MODE_INIT;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
        end
    end

    // next state and mode
    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        unique case (r_state)
            ST_IDLE:  if (i_in_valid) n_state = i_sts.du_in ? ST_PCT : ST_MODE;
            ST_PCT:   n_state = ST_TGT;
            ST_TGT:   n_state = ST_WTGT;
            ST_WTGT:  n_state = ST_MAG;
            ST_MAG:   n_state = ST_URATE;
            ST_URATE: n_state = ST_MODE;
            ST_MODE: begin
                unique case (r_mode)
                    MODE_INIT: begin
                        n_state = ST_DONE;
                        if (i_sts.init_done) begin
                            if (i_sts.pe) begin
                                n_mode  = MODE_PREFUSION;
                                n_state = ST_XMUL;
                            end else begin
                                n_mode  = MODE_BREW;
                            end
                        end
                    end
                    MODE_PREFUSION, MODE_BREW: n_state = ST_STEP;
                    default: n_state = ST_DONE;
                endcase
            end
            ST_STEP: begin
                n_state = ST_DONE;
                if (r_mode == MODE_PREFUSION && !i_sts.pe) begin
                    n_mode  = MODE_BREW;
                    n_state = ST_XMUL;
                end else if (r_mode == MODE_BREW && !i_sts.last_pe && i_sts.pe) begin
                    n_mode  = MODE_PREFUSION;
                    n_state = ST_XMUL;
                end
            end
            ST_XMUL:  n_state = ST_XRATE;
            ST_XRATE: n_state = ST_DONE;
            ST_DONE:  if (i_sts.out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd      = '0;
        o_cmd.mode = r_mode;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            ST_PCT: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_PCT;
            end
            ST_TGT: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_TGT;
            end
            ST_WTGT: o_cmd.tgt_prod = 1'b1;
            ST_MAG: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_DIFF;
                o_cmd.div_sel = DIV_UPD;
            end
            ST_URATE: begin
                o_cmd.div_sel  = DIV_UPD;
                o_cmd.rate_upd = 1'b1;
            end
            ST_MODE: begin
                unique case (r_mode)
                    MODE_INIT: begin
                        o_cmd.val_full = 1'b1;
                        o_cmd.cnt_step = 1'b1;
                        if (i_sts.init_done) begin
                            o_cmd.cnt_clr = 1'b1;
                            if (i_sts.pe) begin
                                o_cmd.tgt_pref = 1'b1;
                            end else begin
                                o_cmd.tgt_full  = 1'b1;
                                o_cmd.rate_zero = 1'b1;
                            end
                        end
                    end
                    MODE_PREFUSION, MODE_BREW: begin
                        o_cmd.mul_en  = 1'b1;
                        o_cmd.mul_sel = MUL_STEP;
                    end
                    default: ;
                endcase
            end
            ST_STEP: begin
                o_cmd.val_step = 1'b1;
                if (r_mode == MODE_PREFUSION && !i_sts.pe) begin
                    o_cmd.tgt_full = 1'b1;
                end else if (r_mode == MODE_BREW && !i_sts.last_pe && i_sts.pe) begin
                    o_cmd.tgt_pref = 1'b1;
                end
            end
            ST_XMUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_DIFF;
                o_cmd.div_sel = (r_mode == MODE_PREFUSION) ? DIV_PREF : DIV_BREW;
            end
            ST_XRATE: begin
                o_cmd.div_sel = (r_mode == MODE_PREFUSION) ? DIV_PREF : DIV_BREW;
                o_cmd.rate_x  = 1'b1;
            end
            ST_DONE: begin
                o_cmd.out_load  = i_sts.out_free;
                o_cmd.last_load = i_sts.out_free;
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

FILE: design/pump_duty_ramp_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pump_duty_ramp_controller
// Pump duty ramp controller: init / prefusion / brew modes, duty ramping
// towards a target at a clamped rate, one result item per control tick.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  i_in     in   valid/ready    prefusion_enable, duty_update, duty_percent
//  o_out    out  valid/ready    pwm_duty, mode_now
//  i_cfg    in   write enable   i_cfg_idx, i_cfg_data
//
//  one item at a time: an init tick runs idle, mode and done, a ramp tick
//  adds step, a duty update adds pct through urate, and a mode change that
//  needs a new rate adds xmul and xrate. the single shared 27x27 multiplier
//  does the percent product, the reciprocal divisions and the ramp step in
//  turn. reset is synchronous, active low; state, config and ramp registers
//  take their defaults. results wait in an output register; an output stall
//  holds the tick only in done, the next item is taken while a result waits.
// ----------------------------------------------------------------------------
module pump_duty_ramp_controller
    import pdrc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    pdrc_in_if.sink                   i_in,
    pdrc_out_if.source                o_out,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    in_ready;

    pdrc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pdrc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_pe        (i_in.prefusion_enable),
        .i_du        (i_in.duty_update),
        .i_pct       (i_in.duty_percent),
        .i_out_ready (o_out.ready),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out.valid),
        .o_pwm       (o_out.pwm_duty),
        .o_mode      (o_out.mode_now)
    );

    assign i_in.ready = in_ready;

    // no second item is taken while one is in work
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("item accepted while another is in work");

    // a finished tick always shows up on the output
    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |=> o_out.valid)
        else $error("result load did not raise output valid");

    // target multiply only follows the percent product
    a_tgt_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.mul_en && cmd.mul_sel == MUL_TGT) |->
            $past(cmd.mul_en && cmd.mul_sel == MUL_PCT))
        else $error("target multiply without percent product");

endmodule
`default_nettype wire

FILE: verif/tb_pump_duty_ramp_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pump_duty_ramp_controller
// Self-checking bench for the pump duty ramp controller. Control ticks go in
// through the tick channel with random gaps while the result channel stalls at
// random. Each accepted tick runs through a bit-exact duty and mode predictor
// kept in a scoreboard, and every result item is compared field by field
// against the oldest prediction. Registers change only between phases.
// ----------------------------------------------------------------------------
module tb_pump_duty_ramp_controller;
    import pdrc_pkg::*;

    typedef struct packed {
        logic [DUTY_W-1:0] pwm_duty;
        t_mode             mode_now;
    } t_duty_mode;

    class duty_ramp_scoreboard;
        logic [DUTY_W-1:0]        max_duty;
        logic [DUTY_W-1:0]        pref_duty;
        logic [DUTY_W-1:0]        off_duty;
        logic [CNT_W-1:0]         init_ticks;
        t_mode                    mode;
        logic [VAL_W-1:0]         duty_value;
        logic [VAL_W-1:0]         duty_target;
        logic signed [RATE_W-1:0] ramp_rate;
        logic [CNT_W-1:0]         init_count;
        logic                     last_pe;
        t_duty_mode               duty_mode_q[$];
        int                       ticks;
        int                       results;
        int                       updates;
        int                       mode_changes;
        int                       errors;

        function new();
            max_duty     = MAX_DUTY_RST;
            pref_duty    = PREF_DUTY_RST;
            off_duty     = OFF_DUTY_RST;
            init_ticks   = INIT_TICKS_RST;
            mode         = MODE_INIT;
            duty_value   = '0;
            duty_target  = '0;
            ramp_rate    = '0;
            init_count   = '0;
            last_pe      = 1'b0;
            ticks        = 0;
            results      = 0;
            updates      = 0;
            mode_changes = 0;
            errors       = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_MAX_DUTY:   max_duty   = data[DUTY_W-1:0];
                CFG_PREF_DUTY:  pref_duty  = data[DUTY_W-1:0];
                CFG_OFF_DUTY:   off_duty   = data[DUTY_W-1:0];
                CFG_INIT_TICKS: init_ticks = data[CNT_W-1:0];
                default: ;
            endcase
        endfunction

        // Q.12 rate covering a Q.8 duty difference in ms, saturated to 16 bits
        function longint slope_over(longint from_v, longint to_v, longint ms);
            longint x;
            x = ((to_v - from_v) * 16) / ms;
            if (x > longint'(RATE_POS_SAT)) x = longint'(RATE_POS_SAT);
            if (x < -longint'(RATE_NEG_SAT)) x = -longint'(RATE_NEG_SAT);
            return x;
        endfunction

        function longint ramp_toward();
            longint rate;
            longint tgt;
            longint v;
            longint lo;
            longint hi;
            rate = longint'(ramp_rate);
            tgt  = longint'(duty_target);
            // arithmetic shift floors the Q.12 step down to Q.8
            v    = longint'(duty_value) + ((rate * TICK_MS) >>> Q_SHIFT);
            lo   = longint'(off_duty) << FRAC_BITS;
            hi   = longint'(max_duty) << FRAC_BITS;
            if (rate >= 0) begin
                if (v > tgt) v = tgt;
            end else if (v < tgt) begin
                v = tgt;
            end
            if (v < lo) v = lo;
            if (v > hi) v = hi;
            return v;
        endfunction

        function void log_tick(bit pe, bit du, logic [PCT_W-1:0] pct_in);
            longint     full;
            longint     pref;
            longint     pct;
            longint     diff;
            longint     mag;
            t_mode      was;
            t_duty_mode r;
            full = longint'(max_duty) << FRAC_BITS;
            pref = longint'(pref_duty) << FRAC_BITS;
            pct  = longint'(pct_in);
            if (pct > PCT_MAX) pct = PCT_MAX;
            was = mode;

            if (du) begin
                updates++;
                duty_target = VAL_W'((pct * longint'(max_duty) * (1 << FRAC_BITS)
                                      + TGT_ROUND) / TGT_DIV);
                diff = longint'(duty_target) - longint'(duty_value);
                mag  = ((diff < 0 ? -diff : diff) * 16) / UPDATE_PERIOD_MS;
                if (mag < RATE_MIN) mag = RATE_MIN;
                if (mag > RATE_MAX) mag = RATE_MAX;
                // zero difference still gives a negative rate
                ramp_rate = RATE_W'(diff > 0 ? mag : -mag);
            end

            case (mode)
                MODE_INIT: begin
                    duty_value = VAL_W'(full);
                    if (init_count != '1) init_count++;
                    if (init_count >= init_ticks) begin
                        if (pe) begin
                            duty_target = VAL_W'(pref);
                            ramp_rate   = RATE_W'(slope_over(full, pref, TO_PREFUSION_MS));
                            mode        = MODE_PREFUSION;
                        end else begin
                            duty_target = VAL_W'(full);
                            ramp_rate   = '0;
                            mode        = MODE_BREW;
                        end
                        init_count = '0;
                    end
                end
                MODE_PREFUSION: begin
                    duty_value = VAL_W'(ramp_toward());
                    if (!pe) begin
                        duty_target = VAL_W'(full);
                        ramp_rate   = RATE_W'(slope_over(longint'(duty_value), full,
                                                         TO_BREW_MS));
                        mode        = MODE_BREW;
                    end
                end
                MODE_BREW: begin
                    duty_value = VAL_W'(ramp_toward());
                    if (!last_pe && pe) begin
                        duty_target = VAL_W'(pref);
                        ramp_rate   = RATE_W'(slope_over(longint'(duty_value), pref,
                                                         TO_PREFUSION_MS));
                        mode        = MODE_PREFUSION;
                    end
                end
                default: ;
            endcase
            last_pe = pe;

            if (mode != was) mode_changes++;
            ticks++;
            r.pwm_duty = duty_value[VAL_W-1:FRAC_BITS];
            r.mode_now = mode;
            duty_mode_q.push_back(r);
        endfunction

        function void match_result(logic [DUTY_W-1:0] pwm, logic [MODE_W-1:0] md);
            t_duty_mode e;
            if (duty_mode_q.size() == 0) begin
                $error("result item with no tick pending: pwm_duty %0d mode_now %0d",
                       pwm, md);
                errors++;
                return;
            end
            e = duty_mode_q.pop_front();
            results++;
            if (pwm !== e.pwm_duty) begin
                $error("pwm_duty: expected %0d, got %0d", e.pwm_duty, pwm);
                errors++;
            end
            if (md !== e.mode_now) begin
                $error("mode_now: expected %0d, got %0d", e.mode_now, md);
                errors++;
            end
        endfunction

        function int pending();
            return duty_mode_q.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    pdrc_in_if  in_if ();
    pdrc_out_if out_if ();

    duty_ramp_scoreboard sb;
    bit                  in_quiet;
    bit                  out_quiet;
    int                  settings_used;

    pump_duty_ramp_controller DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [DUTY_W-1:0] random_duty();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return DUTY_W'($urandom_range(0, (1 << DUTY_W) - 1));
        endcase
    endfunction

    // mostly low so the lower clamp stays below the ramp, now and then above max
    function automatic logic [DUTY_W-1:0] random_off();
        case ($urandom_range(0, 7))
            0: return '1;
            1: return DUTY_W'($urandom_range(0, (1 << DUTY_W) - 1));
            default: return DUTY_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [CNT_W-1:0] random_ticks();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            default: return CNT_W'($urandom_range(0, (1 << CNT_W) - 1));
        endcase
    endfunction

    function automatic logic [PCT_W-1:0] random_pct();
        if ($urandom_range(0, 7) == 0)
            return PCT_W'($urandom_range(PCT_MAX + 1, (1 << PCT_W) - 1));
        return PCT_W'($urandom_range(0, PCT_MAX));
    endfunction

    task automatic send_tick(bit pe, bit du, logic [PCT_W-1:0] pct);
        int gap;
        gap = in_quiet ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid            <= 1'b1;
        in_if.prefusion_enable <= pe;
        in_if.duty_update      <= du;
        in_if.duty_percent     <= pct;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        sb.log_tick(pe, du, pct);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
    endtask

    // registers only change once every result of the phase is out
    task automatic apply_settings(input logic [DUTY_W-1:0] mx, pr, off,
                                  input logic [CNT_W-1:0] it);
        in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        write_reg(CFG_MAX_DUTY, CFG_W'(mx));
        write_reg(CFG_PREF_DUTY, CFG_W'(pr));
        write_reg(CFG_OFF_DUTY, CFG_W'(off));
        write_reg(CFG_INIT_TICKS, CFG_W'(it));
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // result side
    initial begin
        int stall;
        out_if.ready <= 1'b0;
        repeat (12) @(posedge i_clk);
        forever begin
            stall = out_quiet ? 0 : $urandom_range(0, 14);
            if (stall != 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (out_if.valid !== 1'b1);
            sb.match_result(out_if.pwm_duty, out_if.mode_now);
        end
    end

    initial begin
        bit pe;
        bit noisy;
        int run_len;
        int n;
        sb = new();
        i_rst_n                <= 1'b0;
        in_if.valid            <= 1'b0;
        in_if.prefusion_enable <= 1'b0;
        in_if.duty_update      <= 1'b0;
        in_if.duty_percent     <= '0;
        i_cfg_we               <= 1'b0;
        i_cfg_idx              <= CFG_MAX_DUTY;
        i_cfg_data             <= '0;
        in_quiet      = 1'b0;
        out_quiet     = 1'b0;
        settings_used = 0;
        pe            = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // duty updates during init, one with a percent above hundred
        send_tick(1'b1, 1'b1, 7'd127);
        send_tick(1'b1, 1'b0, 7'd0);
        send_tick(1'b0, 1'b1, 7'd0);
        apply_settings(10'd1023, 10'd512, 10'd0, 16'hFFFF);
        send_tick(1'b1, 1'b0, 7'd0);
        // zero init ticks: init is left on the next tick
        apply_settings(10'd1023, 10'd512, 10'd0, 16'd0);
        repeat (3) send_tick(1'b1, 1'b0, 7'd0);
        send_tick(1'b1, 1'b1, 7'd100);
        send_tick(1'b1, 1'b1, 7'd50);
        send_tick(1'b0, 1'b0, 7'd0);
        send_tick(1'b0, 1'b1, 7'd0);
        send_tick(1'b0, 1'b1, 7'd0);
        send_tick(1'b1, 1'b0, 7'd0);
        send_tick(1'b1, 1'b1, 7'd64);
        // off above max, then updates that leave no difference
        apply_settings(10'd0, 10'd1023, 10'd1023, 16'd1);
        send_tick(1'b1, 1'b0, 7'd0);
        send_tick(1'b1, 1'b1, 7'd37);
        send_tick(1'b0, 1'b1, 7'd100);
        send_tick(1'b1, 1'b0, 7'd5);
        apply_settings(10'd1023, 10'd0, 10'd1023, 16'd300);
        send_tick(1'b1, 1'b1, 7'd0);
        send_tick(1'b0, 1'b0, 7'd0);
        send_tick(1'b1, 1'b1, 7'd100);

        // runs of steady enable so ramps play out, some runs pure noise
        for (int ph = 0; ph < 8; ph++) begin
            apply_settings(random_duty(), random_duty(), random_off(), random_ticks());
            in_quiet  = ($urandom_range(0, 3) == 0);
            out_quiet = ($urandom_range(0, 3) == 0);
            n = 0;
            while (n < 92) begin
                noisy   = ($urandom_range(0, 4) == 0);
                pe      = ~pe;
                run_len = $urandom_range(1, 24);
                for (int k = 0; k < run_len && n < 92; k++) begin
                    send_tick(noisy ? bit'($urandom_range(0, 1)) : pe,
                              $urandom_range(0, 3) == 0, random_pct());
                    n++;
                end
            end
        end

        in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("%0d ticks across %0d register settings, %0d with a duty update",
                 sb.ticks, settings_used, sb.updates);
        $display("%0d mode changes seen, %0d results compared, %0d errors",
                 sb.mode_changes, sb.results, sb.errors);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #5ms;
        $display("timeout: results still pending");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: files.f
design/pdrc_pkg.sv
design/pdrc_in_if.sv
design/pdrc_out_if.sv
design/pdrc_dp.sv
design/pdrc_ctrl.sv
design/pump_duty_ramp_controller.sv
verif/tb_pump_duty_ramp_controller.sv
